FILE: hdl/csvf_pkg.sv
// ----------------------------------------------------------------------------
// Crossed-strings view factor: shared package
// Widths, saturation limits and the result beat type used by the
// view-factor pipeline and its checker.
// ----------------------------------------------------------------------------
package csvf_pkg;

    // Default coordinate width (signed fixed point).
    localparam int COORD_BITS_DEF = 24;

    // Width of the coefficient and of the threshold register.
    localparam int COEF_BITS = 28;

    localparam logic signed [COEF_BITS-1:0] COEF_MAX = {1'b0, {(COEF_BITS-1){1'b1}}};
    localparam logic signed [COEF_BITS-1:0] COEF_MIN = {1'b1, {(COEF_BITS-1){1'b0}}};

    // One result beat.
    typedef struct packed {
        logic signed [COEF_BITS-1:0] coefficient;
        logic                        clamped;
    } coef_beat_t;

endpackage

FILE: hdl/csvf_dist_lane.sv
// ----------------------------------------------------------------------------
// Crossed-strings view factor: distance lane
// Pipelined floor(sqrt(dx^2 + dy^2)) between two points, one root bit
// per stage.
// ----------------------------------------------------------------------------
module csvf_dist_lane #(
    parameter int COORD_BITS = csvf_pkg::COORD_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         en,
    input  logic signed [COORD_BITS-1:0] ax,
    input  logic signed [COORD_BITS-1:0] ay,
    input  logic signed [COORD_BITS-1:0] bx,
    input  logic signed [COORD_BITS-1:0] by,
    output logic        [COORD_BITS:0]   root
);

    localparam int RB    = COORD_BITS + 1;
    localparam int SUM_W = 2 * COORD_BITS + 1;
    localparam int RAD_W = 2 * RB;
    localparam int REM_W = RB + 2;

    logic signed [COORD_BITS:0]   dx_reg, dy_reg, dx_next, dy_next;
    logic signed [COORD_BITS:0]   negx, negy;
    logic [COORD_BITS-1:0]        magx_reg, magy_reg, magx_next, magy_next;
    logic [2*COORD_BITS-1:0]      sqx_reg, sqy_reg;
    logic [SUM_W-1:0]             sum_reg;

    logic [REM_W-1:0]             rem_reg [RB];
    logic [RB-1:0]                rt_reg  [RB];
    logic [RAD_W-1:0]             rad_reg [RB];

    assign dx_next = (COORD_BITS+1)'(ax) - (COORD_BITS+1)'(bx);
    assign dy_next = (COORD_BITS+1)'(ay) - (COORD_BITS+1)'(by);

    // The difference of two in-range coordinates never reaches the most
    // negative value, so the magnitude always fits the coordinate width.
    assign negx      = -dx_reg;
    assign negy      = -dy_reg;
    assign magx_next = dx_reg[COORD_BITS] ? negx[COORD_BITS-1:0] : dx_reg[COORD_BITS-1:0];
    assign magy_next = dy_reg[COORD_BITS] ? negy[COORD_BITS-1:0] : dy_reg[COORD_BITS-1:0];

    always_ff @(posedge aclk) begin
        if (en) begin
            dx_reg   <= dx_next;
            dy_reg   <= dy_next;
            magx_reg <= magx_next;
            magy_reg <= magy_next;
            sqx_reg  <= magx_reg * magx_reg;
            sqy_reg  <= magy_reg * magy_reg;
            sum_reg  <= SUM_W'(sqx_reg) + SUM_W'(sqy_reg);
        end
    end

    // Restoring square root: each stage brings down one bit pair of the
    // radicand and decides one root bit.
    for (genvar i = 0; i < RB; i++) begin : g_step
        logic [REM_W-1:0] rem_in, rem_next;
        logic [RB-1:0]    rt_in, rt_next;
        logic [RAD_W-1:0] rad_in;
        logic [REM_W+1:0] cand, trial;

        if (i == 0) begin : g_first
            assign rem_in = '0;
            assign rt_in  = '0;
            assign rad_in = RAD_W'(sum_reg);
        end else begin : g_rest
            assign rem_in = rem_reg[i-1];
            assign rt_in  = rt_reg[i-1];
            assign rad_in = rad_reg[i-1];
        end

        always_comb begin
            cand  = {rem_in, rad_in[RAD_W-1 -: 2]};
            trial = (REM_W+2)'({rt_in, 2'b01});
            if (cand >= trial) begin
                rem_next = REM_W'(cand - trial);
                rt_next  = {rt_in[RB-2:0], 1'b1};
            end else begin
                rem_next = REM_W'(cand);
                rt_next  = {rt_in[RB-2:0], 1'b0};
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[i] <= rem_next;
                rt_reg[i]  <= rt_next;
                rad_reg[i] <= {rad_in[RAD_W-3:0], 2'b00};
            end
        end
    end

    assign root = rt_reg[RB-1];

endmodule

FILE: hdl/crossed_string_view_factor_top.sv
// ----------------------------------------------------------------------------
// Crossed-strings view factor: top level
// Streams segment pairs in and returns r12 + r21 - r22 - r11 per pair.
// ----------------------------------------------------------------------------
// The block accepts one segment pair per clock cycle while s_ready is high
// and returns one result beat per pair, in order. From an accepted input
// beat to the output, four stages form the differences, magnitudes,
// squares and their sum, one stage per root bit (COORD_BITS + 1 of them)
// resolves the four square roots side by side, three stages combine,
// compare and saturate, and one output register holds the result. The rate
// is set by the pipeline as a whole; the four distance lanes work in
// parallel. A two-entry output buffer lets the pipeline take one more input
// beat after the output stalls. There is no state between items. The user
// must write min_coefficient through the configuration channel only while
// the block is idle; the block does not enforce this. It resets to zero.
module crossed_string_view_factor_top #(
    parameter int COORD_BITS = csvf_pkg::COORD_BITS_DEF
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,

    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic signed [COORD_BITS-1:0]           s_own_start_x,
    input  logic signed [COORD_BITS-1:0]           s_own_start_y,
    input  logic signed [COORD_BITS-1:0]           s_own_end_x,
    input  logic signed [COORD_BITS-1:0]           s_own_end_y,
    input  logic signed [COORD_BITS-1:0]           s_other_start_x,
    input  logic signed [COORD_BITS-1:0]           s_other_start_y,
    input  logic signed [COORD_BITS-1:0]           s_other_end_x,
    input  logic signed [COORD_BITS-1:0]           s_other_end_y,

    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic signed [csvf_pkg::COEF_BITS-1:0]  m_coefficient,
    output logic                                   m_clamped,

    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic signed [csvf_pkg::COEF_BITS-1:0]  cfg_data
);

    import csvf_pkg::*;

    localparam int RB       = COORD_BITS + 1;
    localparam int LANE_LAT = RB + 4;
    localparam int PIPE_LAT = LANE_LAT + 3;
    localparam int RAW_W    = RB + 2;
    localparam int CMP_W    = (RAW_W > COEF_BITS) ? RAW_W : COEF_BITS;

    logic                        pipe_en;
    logic [PIPE_LAT-1:0]         pipe_valid_reg, pipe_valid_next;
    logic [RB-1:0]               r11, r22, r12, r21;
    logic [RB:0]                 sum_pos_reg, sum_neg_reg;
    logic signed [RAW_W-1:0]     raw_reg, raw_next;
    logic signed [CMP_W-1:0]     raw_ext, min_ext, hi_ext, lo_ext;
    coef_beat_t                  res_reg, res_next;
    logic signed [COEF_BITS-1:0] min_coefficient_reg;

    coef_beat_t                  out_reg, skid_reg;
    logic                        out_valid_reg, skid_valid_reg;
    logic                        take, out_free;

    // The pipeline moves whenever the skid entry is empty, so a stalled
    // output costs one more beat before input is held off.
    assign pipe_en   = !skid_valid_reg;
    assign s_ready   = pipe_en;
    assign cfg_ready = 1'b1;

    // Four endpoint distances: r11 = |S1 E2|, r22 = |E1 S2|,
    // r12 = |S1 S2|, r21 = |E1 E2|.
    csvf_dist_lane #(.COORD_BITS(COORD_BITS)) u_lane_r11 (
        .aclk (aclk), .en (pipe_en),
        .ax (s_own_start_x), .ay (s_own_start_y),
        .bx (s_other_end_x), .by (s_other_end_y),
        .root (r11)
    );

    csvf_dist_lane #(.COORD_BITS(COORD_BITS)) u_lane_r22 (
        .aclk (aclk), .en (pipe_en),
        .ax (s_own_end_x), .ay (s_own_end_y),
        .bx (s_other_start_x), .by (s_other_start_y),
        .root (r22)
    );

    csvf_dist_lane #(.COORD_BITS(COORD_BITS)) u_lane_r12 (
        .aclk (aclk), .en (pipe_en),
        .ax (s_own_start_x), .ay (s_own_start_y),
        .bx (s_other_start_x), .by (s_other_start_y),
        .root (r12)
    );

    csvf_dist_lane #(.COORD_BITS(COORD_BITS)) u_lane_r21 (
        .aclk (aclk), .en (pipe_en),
        .ax (s_own_end_x), .ay (s_own_end_y),
        .bx (s_other_end_x), .by (s_other_end_y),
        .root (r21)
    );

    // Valid bits shift alongside the data through every stage.
    assign pipe_valid_next = {pipe_valid_reg[PIPE_LAT-2:0], s_valid};

    assign raw_next = $signed({1'b0, sum_pos_reg}) - $signed({1'b0, sum_neg_reg});

    // The threshold test uses the exact sum; saturation applies only to a
    // coefficient that was not clamped.
    always_comb begin
        raw_ext  = CMP_W'(raw_reg);
        min_ext  = CMP_W'(min_coefficient_reg);
        hi_ext   = CMP_W'(COEF_MAX);
        lo_ext   = CMP_W'(COEF_MIN);
        res_next = '0;
        if (raw_ext < min_ext) begin
            res_next.clamped = 1'b1;
        end else if (raw_ext > hi_ext) begin
            res_next.coefficient = COEF_MAX;
        end else if (raw_ext < lo_ext) begin
            res_next.coefficient = COEF_MIN;
        end else begin
            res_next.coefficient = raw_ext[COEF_BITS-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            sum_pos_reg <= (RB+1)'(r12) + (RB+1)'(r21);
            sum_neg_reg <= (RB+1)'(r22) + (RB+1)'(r11);
            raw_reg     <= raw_next;
            res_reg     <= res_next;
        end
    end

    // Output register with one skid entry behind it.
    assign take     = pipe_en && pipe_valid_reg[PIPE_LAT-1];
    assign out_free = !out_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pipe_valid_reg      <= '0;
            out_valid_reg       <= 1'b0;
            skid_valid_reg      <= 1'b0;
            min_coefficient_reg <= '0;
        end else begin
            if (pipe_en) begin
                pipe_valid_reg <= pipe_valid_next;
            end
            if (cfg_valid && cfg_ready) begin
                min_coefficient_reg <= cfg_data;
            end
            if (out_free) begin
                if (skid_valid_reg) begin
                    out_valid_reg  <= 1'b1;
                    skid_valid_reg <= 1'b0;
                end else begin
                    out_valid_reg <= take;
                end
            end else if (take) begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free) begin
            if (skid_valid_reg) begin
                out_reg <= skid_reg;
            end else if (take) begin
                out_reg <= res_reg;
            end
        end else if (take) begin
            skid_reg <= res_reg;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_coefficient = out_reg.coefficient;
    assign m_clamped     = out_reg.clamped;

endmodule

FILE: hdl/csvf_checker.sv
// ----------------------------------------------------------------------------
// Crossed-strings view factor: port checker
// Watches the top level's ports and is bound to every instance of it.
// ----------------------------------------------------------------------------
module csvf_checker (
    input logic                                  aclk,
    input logic                                  aresetn,
    input logic                                  m_valid,
    input logic                                  m_ready,
    input logic signed [csvf_pkg::COEF_BITS-1:0] m_coefficient,
    input logic                                  m_clamped,
    input logic                                  cfg_valid,
    input logic                                  cfg_ready,
    input logic signed [csvf_pkg::COEF_BITS-1:0] cfg_data
);

    import csvf_pkg::*;

    logic signed [COEF_BITS-1:0] min_copy_reg;

    // Shadow of the threshold, taken from the configuration beats.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_copy_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            min_copy_reg <= cfg_data;
        end
    end

    a_reset_clears_output: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result beat shown straight after reset");

    a_stall_holds_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_coefficient) && $stable(m_clamped))
        else $error("stalled result beat changed or vanished");

    a_clamp_gives_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_clamped |-> m_coefficient == '0)
        else $error("clamped result carries a non-zero coefficient");

    a_result_above_min: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_clamped |-> m_coefficient >= min_copy_reg)
        else $error("unclamped coefficient lies below the threshold");

endmodule

bind crossed_string_view_factor_top csvf_checker u_csvf_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_coefficient (m_coefficient),
    .m_clamped     (m_clamped),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
);
